### src/tppg_pkg.sv
package tppg_pkg;

	// Widths of the coordinate and pixel fields.
	localparam int X_W   = 9;
	localparam int Y_W   = 8;
	localparam int PIX_W = 16;

	// Default frame size.
	localparam int DEF_FRAME_WIDTH  = 320;
	localparam int DEF_FRAME_HEIGHT = 240;

	// Constant division is done as a multiply by a rounded-up reciprocal.
	// A shift of 28 keeps the quotient exact for every numerator below 2^17
	// and every divisor up to 2048.
	localparam int RECIP_SHIFT = 28;
	localparam int RECIP_W     = RECIP_SHIFT + 1;
	localparam int NUM_W       = 17;
	localparam int PROD_W      = NUM_W + RECIP_W;
	localparam int QUOT_W      = 14;

	// Width of the reversed column (frame width minus one, at most 2047).
	localparam int XR_W = 11;

	// Color modes held in the configuration register.
	typedef enum logic [2:0] {
		MODE_IDX8     = 3'd0,
		MODE_IDX4     = 3'd1,
		MODE_IDX2     = 3'd2,
		MODE_RGB565   = 3'd3,
		MODE_RGB555   = 3'd4,
		MODE_RGBA5551 = 3'd5
	} color_mode_t;

	// Quotients and side bits handed from the divide stage to the pack stage.
	typedef struct packed {
		logic [QUOT_W-1:0] qa;        // column quotient, meaning set by the mode
		logic [QUOT_W-1:0] qb;        // blue quotient from the reversed column
		logic [QUOT_W-1:0] qc;        // green quotient from the row
		logic [7:0]        ramp;      // diagonal ramp, (x + y) mod 256
		logic              top_half;  // row lies in the upper half of the frame
		logic              alpha;     // checker bit for RGBA5551
	} quot_t;

endpackage

### src/tppg_quot.sv
module tppg_quot import tppg_pkg::*; #(
	parameter int FRAME_WIDTH  = DEF_FRAME_WIDTH,
	parameter int FRAME_HEIGHT = DEF_FRAME_HEIGHT
) (
	input  color_mode_t      color_mode,
	input  logic [X_W-1:0]   pixel_x,
	input  logic [Y_W-1:0]   pixel_y,
	output quot_t            quot
);

	// Rounded-up reciprocals of the divisors, scaled by 2^RECIP_SHIFT.
	localparam logic [RECIP_W-1:0] RCP_W = RECIP_W'(((64'd1 << RECIP_SHIFT)
		+ 64'(FRAME_WIDTH) - 64'd1) / 64'(FRAME_WIDTH));
	localparam logic [RECIP_W-1:0] RCP_W16 = RECIP_W'(((64'd1 << RECIP_SHIFT)
		+ 64'(FRAME_WIDTH / 16) - 64'd1) / 64'(FRAME_WIDTH / 16));
	localparam logic [RECIP_W-1:0] RCP_W4 = RECIP_W'(((64'd1 << RECIP_SHIFT)
		+ 64'(FRAME_WIDTH / 4) - 64'd1) / 64'(FRAME_WIDTH / 4));
	localparam logic [RECIP_W-1:0] RCP_H = RECIP_W'(((64'd1 << RECIP_SHIFT)
		+ 64'(FRAME_HEIGHT) - 64'd1) / 64'(FRAME_HEIGHT));
	localparam logic [XR_W-1:0] W_M1   = XR_W'(FRAME_WIDTH - 1);
	localparam int              HALF_H = FRAME_HEIGHT / 2;

	logic [NUM_W-1:0]   num_a, num_b, num_c;
	logic [RECIP_W-1:0] rcp_a;
	logic [PROD_W-1:0]  prod_a, prod_b, prod_c;
	logic [XR_W-1:0]    xr;
	logic               x_in_frame;

	// Column unit: numerator and reciprocal follow the mode.
	always_comb begin
		if (color_mode == MODE_IDX8) begin
			num_a = NUM_W'({pixel_x, 8'd0});
			rcp_a = RCP_W;
		end else if (color_mode == MODE_IDX4) begin
			num_a = NUM_W'(pixel_x);
			rcp_a = RCP_W16;
		end else if (color_mode == MODE_IDX2) begin
			num_a = NUM_W'(pixel_x);
			rcp_a = RCP_W4;
		end else begin
			num_a = NUM_W'({pixel_x, 5'd0}) - NUM_W'(pixel_x);
			rcp_a = RCP_W;
		end
	end

	// Reversed column stops at zero outside the frame.
	assign x_in_frame = 32'(pixel_x) < 32'(FRAME_WIDTH);
	assign xr         = x_in_frame ? (W_M1 - XR_W'(pixel_x)) : '0;
	assign num_b      = NUM_W'({xr, 5'd0}) - NUM_W'(xr);

	// Row unit: 63 steps for RGB565, 31 otherwise.
	always_comb begin
		if (color_mode == MODE_RGB565) begin
			num_c = NUM_W'({pixel_y, 6'd0}) - NUM_W'(pixel_y);
		end else begin
			num_c = NUM_W'({pixel_y, 5'd0}) - NUM_W'(pixel_y);
		end
	end

	// Three independent reciprocal multiplies.
	assign prod_a = PROD_W'(num_a) * PROD_W'(rcp_a);
	assign prod_b = PROD_W'(num_b) * PROD_W'(RCP_W);
	assign prod_c = PROD_W'(num_c) * PROD_W'(RCP_H);

	// Quotients and the cheap side terms.
	always_comb begin
		quot.qa       = prod_a[RECIP_SHIFT +: QUOT_W];
		quot.qb       = prod_b[RECIP_SHIFT +: QUOT_W];
		quot.qc       = prod_c[RECIP_SHIFT +: QUOT_W];
		quot.ramp     = pixel_x[7:0] + pixel_y;
		quot.top_half = 32'(pixel_y) < 32'(HALF_H);
		quot.alpha    = pixel_x[3] ^ pixel_y[3];
	end

endmodule

### src/tppg_pack.sv
module tppg_pack import tppg_pkg::*; (
	input  color_mode_t       color_mode,
	input  quot_t             quot,
	output logic [PIX_W-1:0]  pixel_value
);

	logic [4:0] r5, b5, g5;
	logic [5:0] g6;

	// Clamp each color component at its field maximum.
	assign r5 = (quot.qa > QUOT_W'(31)) ? 5'd31 : quot.qa[4:0];
	assign b5 = (quot.qb > QUOT_W'(31)) ? 5'd31 : quot.qb[4:0];
	assign g5 = (quot.qc > QUOT_W'(31)) ? 5'd31 : quot.qc[4:0];
	assign g6 = (quot.qc > QUOT_W'(63)) ? 6'd63 : quot.qc[5:0];

	// Pack the pixel in the format of the mode; unused codes give zero.
	always_comb begin
		case (color_mode)
			MODE_IDX8: begin
				pixel_value = quot.top_half ? {8'd0, quot.ramp} : {8'd0, quot.qa[7:0]};
			end
			MODE_IDX4:     pixel_value = {12'd0, quot.qa[3:0]};
			MODE_IDX2:     pixel_value = {14'd0, quot.qa[1:0]};
			MODE_RGB565:   pixel_value = {r5, g6, b5};
			MODE_RGB555:   pixel_value = {1'b0, r5, g5, b5};
			MODE_RGBA5551: pixel_value = {r5, g5, b5, quot.alpha};
			default:       pixel_value = '0;
		endcase
	end

endmodule

### src/test_pattern_pixel_generator_top.sv
// Test pattern pixel generator.
//
// Input channel: in_valid, in_stall, pixel_x, pixel_y. One beat carries one
// pixel coordinate. Output channel: out_valid, out_stall, pixel_value. One
// beat carries the value of that pixel, in the order the coordinates came.
// The color mode is written through cfg_wr_en and cfg_wr_data; the user
// must write it only while the block is idle, which is not enforced.
//
// The block is a three-stage pipeline: input register, a divide stage of
// three reciprocal multipliers, and the output register after packing. A
// result passes through the input and divide stage registers before the
// output register offers it. One coordinate is accepted every cycle while
// in_stall is low; the rate is set by the single divide-stage pass.
//
// When the receiver stalls, the output register holds its beat and each
// stage still fills any empty slot behind it, so up to three beats are held
// before in_stall rises. Reset empties the pipeline and sets the color mode
// to the 8-bit index ramp.
module test_pattern_pixel_generator_top import tppg_pkg::*; #(
	parameter int FRAME_WIDTH  = DEF_FRAME_WIDTH,
	parameter int FRAME_HEIGHT = DEF_FRAME_HEIGHT
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wr_en,
	input  logic [2:0]        cfg_wr_data,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [X_W-1:0]    pixel_x,
	input  logic [Y_W-1:0]    pixel_y,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [PIX_W-1:0]  pixel_value
);

	color_mode_t       color_mode_q;
	logic              v_s1, v_s2, out_valid_q;
	logic [X_W-1:0]    x_s1;
	logic [Y_W-1:0]    y_s1;
	quot_t             quot_c, q_s2;
	logic [PIX_W-1:0]  pix_c, pixel_value_q;
	logic              out_ready, s2_ready, s1_ready;

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			color_mode_q <= MODE_IDX8;
		end else if (cfg_wr_en) begin
			color_mode_q <= color_mode_t'(cfg_wr_data);
		end
	end

	// Each stage moves when its own slot is empty or the next one takes it.
	assign out_ready = !out_valid_q || !out_stall;
	assign s2_ready  = !v_s2 || out_ready;
	assign s1_ready  = !v_s1 || s2_ready;
	assign in_stall  = !s1_ready;

	// Stage valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s1_ready) begin
				v_s1 <= in_valid;
			end
			if (s2_ready) begin
				v_s2 <= v_s1;
			end
			if (out_ready) begin
				out_valid_q <= v_s2;
			end
		end
	end

	// Input register.
	always_ff @(posedge clk) begin
		if (s1_ready && in_valid) begin
			x_s1 <= pixel_x;
			y_s1 <= pixel_y;
		end
	end

	tppg_quot #(
		.FRAME_WIDTH  (FRAME_WIDTH),
		.FRAME_HEIGHT (FRAME_HEIGHT)
	) u_quot (
		.color_mode (color_mode_q),
		.pixel_x    (x_s1),
		.pixel_y    (y_s1),
		.quot       (quot_c)
	);

	// Divide stage register.
	always_ff @(posedge clk) begin
		if (s2_ready && v_s1) begin
			q_s2 <= quot_c;
		end
	end

	tppg_pack u_pack (
		.color_mode  (color_mode_q),
		.quot        (q_s2),
		.pixel_value (pix_c)
	);

	// Output register.
	always_ff @(posedge clk) begin
		if (out_ready && v_s2) begin
			pixel_value_q <= pix_c;
		end
	end

	assign out_valid   = out_valid_q;
	assign pixel_value = pixel_value_q;

	// An accepted beat always lands in the input register.
	a_accept_lands: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> v_s1)
		else $error("accepted beat not captured in input register");

	// Back-pressure only when every stage is full and the output is stalled.
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> v_s1 && v_s2 && out_valid_q && out_stall)
		else $error("input stalled while the pipeline has room");

	// A held divide-stage beat keeps its quotients.
	a_s2_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && !out_ready |=> v_s2 && $stable(q_s2))
		else $error("divide stage lost or changed a held beat");

	// The 4-bit index mode never sets bits above the index.
	a_idx4_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && color_mode_q == MODE_IDX4 |-> pixel_value_q[PIX_W-1:4] == '0)
		else $error("4-bit index out of range");

endmodule

### tb/test_pattern_pixel_generator_top_tb.sv
module test_pattern_pixel_generator_top_tb import tppg_pkg::*;;

	timeunit 1ns;
	timeprecision 1ps;

	// The two codes that the register accepts but that select no pattern.
	localparam logic [2:0] MODE_SPARE6 = 3'd6;
	localparam logic [2:0] MODE_SPARE7 = 3'd7;

	localparam logic [2:0] MODE_ORDER [8] = '{MODE_IDX8, MODE_IDX4, MODE_IDX2,
		MODE_RGB565, MODE_RGB555, MODE_RGBA5551, MODE_SPARE6, MODE_SPARE7};

	localparam int FRAME_W       = DEF_FRAME_WIDTH;
	localparam int FRAME_H       = DEF_FRAME_HEIGHT;
	localparam int BEATS_PER_RUN = 58;
	localparam int LONG_HOLD     = 300;
	localparam int STALL_LIMIT   = 3000;

	typedef struct packed {
		logic [X_W-1:0] x;
		logic [Y_W-1:0] y;
	} coord_t;

	logic clk;
	logic arst_n;
	logic cfg_wr_en;
	logic [2:0] cfg_wr_data;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [X_W-1:0] pixel_x = '0;
	logic [Y_W-1:0] pixel_y = '0;
	logic out_valid;
	logic out_stall = 1'b1;
	logic [PIX_W-1:0] pixel_value;

	coord_t coord_q[$];
	logic [PIX_W-1:0] pixel_expect_q[$];
	logic [2:0] active_mode;
	int send_idle_pct;
	int recv_idle_pct;
	logic hold_req;
	logic hold_seen;
	int hold_cnt;
	int fail_count;
	int quiet_cycles;

	wire in_beat  = in_valid && !in_stall;
	wire out_beat = out_valid && !out_stall;

	test_pattern_pixel_generator_top dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.pixel_x    (pixel_x),
		.pixel_y    (pixel_y),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.pixel_value(pixel_value)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// Clamp a color component to the top of its field.
	function automatic int unsigned clamp_to(int unsigned v, int unsigned top);
		return (v > top) ? top : v;
	endfunction

	// Value of one pixel of the test pattern in the given color mode.
	function automatic logic [PIX_W-1:0] pattern_pixel(logic [2:0] mode,
			logic [X_W-1:0] px, logic [Y_W-1:0] py);
		int unsigned x, y, rev, red, blue, green, alpha, v;
		x = px;
		y = py;
		rev = (x < FRAME_W) ? (FRAME_W - 1 - x) : 0;
		red = clamp_to(x * 31 / FRAME_W, 31);
		blue = clamp_to(rev * 31 / FRAME_W, 31);
		alpha = ((x / 8) + (y / 8)) & 1;
		case (mode)
			MODE_IDX8: begin
				if (y < FRAME_H / 2)
					v = (x + y) & 8'hFF;
				else
					v = (x * 256 / FRAME_W) & 8'hFF;
			end
			MODE_IDX4: v = (x / (FRAME_W / 16)) & 4'hF;
			MODE_IDX2: v = (x / (FRAME_W / 4)) & 2'h3;
			MODE_RGB565: begin
				green = clamp_to(y * 63 / FRAME_H, 63);
				v = (red << 11) | (green << 5) | blue;
			end
			MODE_RGB555: begin
				green = clamp_to(y * 31 / FRAME_H, 31);
				v = (red << 10) | (green << 5) | blue;
			end
			MODE_RGBA5551: begin
				green = clamp_to(y * 31 / FRAME_H, 31);
				v = (red << 11) | (green << 6) | (blue << 1) | alpha;
			end
			default: v = 0;
		endcase
		return v[PIX_W-1:0];
	endfunction

	// Coordinate driver: records the expected pixel for each accepted beat and
	// offers the next pending coordinate unless it chooses to idle.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			pixel_x <= '0;
			pixel_y <= '0;
		end else begin
			if (in_beat)
				pixel_expect_q.push_back(pattern_pixel(active_mode, pixel_x, pixel_y));
			if (!in_valid || in_beat) begin
				if (coord_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					coord_t c;
					c = coord_q.pop_front();
					in_valid <= 1'b1;
					pixel_x <= c.x;
					pixel_y <= c.y;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Pixel monitor and receiver: checks each beat against the oldest expected
	// pixel, then picks the next stall, including one long hold-off on request.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b1;
			hold_seen <= 1'b0;
			hold_cnt <= 0;
			fail_count <= 0;
		end else begin
			if (out_beat) begin
				if (pixel_expect_q.size() == 0) begin
					$error("unexpected pixel beat: pixel_value %h", pixel_value);
					fail_count <= fail_count + 1;
				end else begin
					logic [PIX_W-1:0] want;
					want = pixel_expect_q.pop_front();
					if (pixel_value !== want) begin
						$error("pixel_value mismatch: expected %h, actual %h",
							want, pixel_value);
						fail_count <= fail_count + 1;
					end
				end
			end
			if (hold_cnt > 0) begin
				out_stall <= 1'b1;
				hold_cnt <= hold_cnt - 1;
			end else if (hold_req && !hold_seen) begin
				hold_seen <= 1'b1;
				hold_cnt <= LONG_HOLD;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(99) < recv_idle_pct);
			end
		end
	end

	// Watchdog on cycles in which neither channel moves a beat.
	always @(posedge clk) begin
		if (!arst_n || in_beat || out_beat) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic queue_coord(int x, int y);
		coord_t c;
		c.x = x[X_W-1:0];
		c.y = y[Y_W-1:0];
		coord_q.push_back(c);
	endtask

	// Mostly coordinates inside the frame, with some beyond its right and
	// bottom edges to reach the saturating and wrapping cases.
	task automatic queue_random_coords(int n);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(99) < 15)
				queue_coord($urandom_range((1 << X_W) - 1), $urandom_range((1 << Y_W) - 1));
			else
				queue_coord($urandom_range(FRAME_W - 1), $urandom_range(FRAME_H - 1));
		end
	endtask

	task automatic wait_drained();
		@(negedge clk);
		while (coord_q.size() != 0 || in_valid || pixel_expect_q.size() != 0)
			@(negedge clk);
		repeat (5) @(negedge clk);
	endtask

	task automatic write_mode(logic [2:0] mode);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= mode;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		active_mode = mode;
		@(negedge clk);
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		active_mode = MODE_IDX8;
		send_idle_pct = 27;
		recv_idle_pct = 83;
		hold_req = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed corners, half-frame boundary, bar edges, checker edges and
		// coordinates past the frame, all in the reset mode.
		queue_coord(0, 0);
		queue_coord(FRAME_W - 1, 0);
		queue_coord(0, FRAME_H - 1);
		queue_coord(FRAME_W - 1, FRAME_H - 1);
		queue_coord(FRAME_W / 2 - 1, FRAME_H / 2 - 1);
		queue_coord(FRAME_W / 2, FRAME_H / 2);
		queue_coord(FRAME_W, 0);
		queue_coord(0, FRAME_H);
		queue_coord((1 << X_W) - 1, (1 << Y_W) - 1);
		queue_coord(7, 7);
		queue_coord(8, 8);
		queue_coord(255, 128);
		queue_coord(FRAME_W / 16 - 1, 0);
		queue_coord(FRAME_W / 16, 0);
		queue_coord(FRAME_W / 4 - 1, 3);
		queue_coord(FRAME_W / 4, 3);
		wait_drained();

		// Three idling profiles, each running through every mode code.
		for (int prof = 0; prof < 3; prof++) begin
			send_idle_pct = (prof == 0) ? 27 : (prof == 1) ? 83 : 0;
			recv_idle_pct = (prof == 0) ? 83 : (prof == 1) ? 27 : 0;
			for (int k = 0; k < 8; k++) begin
				write_mode(MODE_ORDER[(prof == 1) ? 7 - k : k]);
				queue_random_coords(BEATS_PER_RUN);
				if (prof == 2 && k == 0)
					hold_req = 1'b1;
				wait_drained();
			end
		end

		repeat (10) @(negedge clk);
		if (fail_count == 0 && pixel_expect_q.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

### filelist.f
src/tppg_pkg.sv
src/tppg_quot.sv
src/tppg_pack.sv
src/test_pattern_pixel_generator_top.sv
tb/test_pattern_pixel_generator_top_tb.sv
